// ----- hdl/apc_pkg.sv -----
// Package for the Aliev-Panfilov cell update block: widths, word types,
// register codes and reset values, saturating add and 32-bit clamp helpers.
// Depends on nothing; the top level, apc_mul, apc_div and the testbench import it.
package apc_pkg;

  // Default fraction width of the fixed-point values
  localparam int FRAC_BITS_DEF = 24;

  // Field and datapath widths
  localparam int WORD_W   = 32;
  localparam int REG_W    = 40;
  localparam int VAL_W    = 63;
  localparam int MAG_W    = VAL_W - 1;
  localparam int HALF_W   = MAG_W / 2;
  localparam int PROD_W   = 2 * MAG_W;
  localparam int SHORT_W  = 42;
  localparam int LAP_W    = 36;
  localparam int NUM_REGS = 8;
  localparam int IDX_W    = 3;

  // Divider geometry: numerator is mu1 times |r|
  localparam int NUM_W   = REG_W + WORD_W;
  localparam int DEN_W   = 41;
  localparam int LO_W    = REG_W / 2;
  localparam int PP_W    = LO_W + WORD_W;
  localparam int DIV_LAT = NUM_W + 3;

  // Multiplier latency in cycles
  localparam int MUL_LAT = 4;

  typedef logic signed [VAL_W-1:0]   val_t;
  typedef logic signed [WORD_W-1:0]  word_t;
  typedef logic signed [SHORT_W-1:0] short_t;
  typedef logic signed [LAP_W-1:0]   lap_t;
  typedef logic [REG_W-1:0]          coef_t;
  typedef logic [MAG_W-1:0]          mag_t;

  // Largest magnitude an intermediate may hold
  localparam mag_t LIM   = '1;
  localparam val_t LIM_V = val_t'({1'b0, LIM});
  localparam val_t W_MAX = (val_t'(1) <<< (WORD_W - 1)) - val_t'(1);
  localparam val_t W_MIN = -(val_t'(1) <<< (WORD_W - 1));

  // Register codes
  typedef enum logic [IDX_W-1:0] {
    REG_TIME_STEP   = 3'd0,
    REG_DIFFUSION   = 3'd1,
    REG_GAIN_K      = 3'd2,
    REG_THRESHOLD_A = 3'd3,
    REG_RECOVERY_B  = 3'd4,
    REG_EPSILON     = 3'd5,
    REG_MU1         = 3'd6,
    REG_MU2         = 3'd7
  } reg_idx_t;

  localparam coef_t REG_RESET [NUM_REGS] = '{
    40'd671, 40'd8589934592, 40'd134217728, 40'd1677722,
    40'd1677722, 40'd167772, 40'd1174405, 40'd5033165
  };

  typedef struct packed {
    word_t excite_center;
    word_t recover_center;
    word_t excite_xm;
    word_t excite_xp;
    word_t excite_ym;
    word_t excite_yp;
    word_t excite_zm;
    word_t excite_zp;
  } in_word_t;

  typedef struct packed {
    word_t excite_next;
    word_t recover_next;
    logic  saturated;
    logic  divide_fault;
  } out_word_t;

  typedef struct packed {
    val_t v;
    logic clip;
  } clip_val_t;

  typedef struct packed {
    word_t v;
    logic  clip;
  } clip_word_t;

  // Magnitude of a value that stays inside +-LIM
  function automatic mag_t magnitude(val_t x);
    return MAG_W'(x[VAL_W-1] ? -x : x);
  endfunction

  // Add and clamp to +-LIM
  function automatic clip_val_t fadd(val_t a, val_t b);
    logic signed [VAL_W:0] s;
    logic signed [VAL_W:0] lim;
    clip_val_t res;
    s   = (VAL_W + 1)'(a) + (VAL_W + 1)'(b);
    lim = (VAL_W + 1)'(LIM_V);
    res.clip = 1'b0;
    res.v    = VAL_W'(s);
    if (s > lim) begin
      res.clip = 1'b1;
      res.v    = LIM_V;
    end else if (s < -lim) begin
      res.clip = 1'b1;
      res.v    = -LIM_V;
    end
    return res;
  endfunction

  // Clamp to the signed 32-bit range
  function automatic clip_word_t sat32(val_t x);
    clip_word_t res;
    res.clip = 1'b0;
    res.v    = WORD_W'(x);
    if (x > W_MAX) begin
      res.clip = 1'b1;
      res.v    = WORD_W'(W_MAX);
    end else if (x < W_MIN) begin
      res.clip = 1'b1;
      res.v    = WORD_W'(W_MIN);
    end
    return res;
  endfunction

endpackage

// ----- hdl/apc_stream_if.sv -----
// Valid/ready stream channel used for the cell words in and out.
// Payload type is a parameter; the block uses the word structs of apc_pkg.
interface apc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/aliev_panfilov_cell_update.sv -----
// Aliev-Panfilov forward-Euler cell update, top level.
//   channel    dir  handshake      payload
//   cell_in    in   valid/ready    apc_pkg::in_word_t  (e, r, six neighbors)
//   cell_out   out  valid/ready    apc_pkg::out_word_t (e', r', flags)
//   cfg_*      in   cfg_we         cfg_index, cfg_data (40-bit coefficient)
// One word enters per cycle while the output is not stalled; the depth of the
// pipeline is set by MUL_LAT and by the one-bit-per-stage divider of DIV_LAT.
// All stages advance together when the output register is empty or read.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset is synchronous, clears stage valids and loads register defaults.
// Uses apc_pkg, apc_stream_if, apc_delay, apc_mul and apc_div.
module aliev_panfilov_cell_update #(
  parameter int FRAC_BITS = apc_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  apc_stream_if.sink                cell_in,
  apc_stream_if.source              cell_out,
  input  logic                      cfg_we,
  input  logic [apc_pkg::IDX_W-1:0] cfg_index,
  input  apc_pkg::coef_t            cfg_data
);
  import apc_pkg::*;

  // Stage numbers of each result
  localparam int ML     = MUL_LAT;
  localparam int T_KE   = ML;
  localparam int T_DL   = 1 + ML;
  localparam int T_T1   = 2 * ML;
  localparam int T_T2   = 3 * ML;
  localparam int T_DEA  = T_T2 + 1;
  localparam int T_DEB  = T_DEA + 1;
  localparam int T_DEC  = T_DEB + ML;
  localparam int T_EN   = T_DEC + 1;
  localparam int T_G1   = 2 * ML;
  localparam int T_G    = T_G1 + 1;
  localparam int T_Q    = 1 + DIV_LAT;
  localparam int T_RATE = T_Q + 1;
  localparam int T_P    = T_RATE + ML;
  localparam int T_P2   = T_P + ML;
  localparam int T_OUT  = T_P2 + 1;

  localparam short_t ONE_S = short_t'(1) <<< FRAC_BITS;

  coef_t       regs [NUM_REGS];
  logic [T_OUT:0] vld;
  logic        adv;

  in_word_t    in0;
  lap_t        lap1;
  short_t      ea1, e11, eb11, den1;
  logic        fault1;
  word_t       r1;
  short_t      den_c;

  val_t        ke, er, dl, t1, t2, g1, dec, p, p2, q;
  logic        ke_c, er_c, dl_c, t1_c, t2_c, g1_c, dec_c, p_c, p2_c, q_c;
  short_t      ea4, eb4, e1_8;
  val_t        dl12, er13;
  logic        dlc12, erc13;
  word_t       e18, r8, r85;
  val_t        dea13, deb14, g9, g77, rate77;
  logic        deac13, debc14, gc9, gc77, ratec77;
  word_t       en19, en85;
  logic        enc19, enc85, f85;

  clip_val_t   dea_s, deb_s, en_s, g_s, rate_s, rn_s;
  clip_word_t  en_w, rn_w;
  out_word_t   out_next;

  // Advance when the output register is free or being read
  assign adv           = !vld[T_OUT] || cell_out.ready;
  assign cell_in.ready = adv;
  assign cell_out.valid = vld[T_OUT];

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= REG_RESET;
    end else if (cfg_we) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[T_OUT-1:0], cell_in.valid};
    end
  end

  // Stage 0: capture the input word
  always_ff @(posedge clk) begin
    if (adv) begin
      in0 <= cell_in.data;
    end
  end

  // Stage 1: Laplacian, shifted excitations and the divisor
  always_comb begin
    den_c = short_t'(regs[REG_MU2]) + short_t'(in0.excite_center);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lap1   <= lap_t'(in0.excite_xm) + lap_t'(in0.excite_xp) + lap_t'(in0.excite_ym)
              + lap_t'(in0.excite_yp) + lap_t'(in0.excite_zm) + lap_t'(in0.excite_zp)
              - (lap_t'(in0.excite_center) <<< 2) - (lap_t'(in0.excite_center) <<< 1);
      ea1    <= short_t'(in0.excite_center) - short_t'(regs[REG_THRESHOLD_A]);
      e11    <= short_t'(in0.excite_center) - ONE_S;
      eb11   <= short_t'(in0.excite_center) - short_t'(regs[REG_RECOVERY_B]) - ONE_S;
      den1   <= den_c;
      fault1 <= den_c <= short_t'(0);
      r1     <= in0.recover_center;
    end
  end

  // k*e and e*r straight from stage 0
  apc_mul #(.FRAC_BITS(FRAC_BITS)) u_ke (
    .clk, .en(adv), .a(val_t'(regs[REG_GAIN_K])), .b(val_t'(in0.excite_center)),
    .clip_in(1'b0), .p(ke), .clip_out(ke_c)
  );

  apc_mul #(.FRAC_BITS(FRAC_BITS)) u_er (
    .clk, .en(adv), .a(val_t'(in0.excite_center)), .b(val_t'(in0.recover_center)),
    .clip_in(1'b0), .p(er), .clip_out(er_c)
  );

  // D times the Laplacian
  apc_mul #(.FRAC_BITS(FRAC_BITS)) u_dl (
    .clk, .en(adv), .a(val_t'(regs[REG_DIFFUSION])), .b(val_t'(lap1)),
    .clip_in(1'b0), .p(dl), .clip_out(dl_c)
  );

  // Align the shifted excitations with k*e and with the first cubic product
  apc_delay #(.WIDTH(SHORT_W), .DEPTH(T_KE - 1)) u_d_ea (
    .clk, .en(adv), .d(ea1), .q(ea4)
  );
  apc_delay #(.WIDTH(SHORT_W), .DEPTH(T_KE - 1)) u_d_eb (
    .clk, .en(adv), .d(eb11), .q(eb4)
  );
  apc_delay #(.WIDTH(SHORT_W), .DEPTH(T_T1 - 1)) u_d_e1 (
    .clk, .en(adv), .d(e11), .q(e1_8)
  );

  // Cubic term: k*e*(e-a)*(e-1)
  apc_mul #(.FRAC_BITS(FRAC_BITS)) u_t1 (
    .clk, .en(adv), .a(ke), .b(val_t'(ea4)), .clip_in(ke_c), .p(t1), .clip_out(t1_c)
  );
  apc_mul #(.FRAC_BITS(FRAC_BITS)) u_t2 (
    .clk, .en(adv), .a(t1), .b(val_t'(e1_8)), .clip_in(t1_c), .p(t2), .clip_out(t2_c)
  );

  // Recovery drive: k*e*(e-b-1)
  apc_mul #(.FRAC_BITS(FRAC_BITS)) u_g1 (
    .clk, .en(adv), .a(ke), .b(val_t'(eb4)), .clip_in(1'b0), .p(g1), .clip_out(g1_c)
  );

  apc_delay #(.WIDTH(VAL_W + 1), .DEPTH(T_T2 - T_DL)) u_d_dl (
    .clk, .en(adv), .d({dl, dl_c}), .q({dl12, dlc12})
  );
  apc_delay #(.WIDTH(VAL_W + 1), .DEPTH(T_DEA - T_KE)) u_d_er (
    .clk, .en(adv), .d({er, er_c}), .q({er13, erc13})
  );

  // Excitation rate: D*lap - cubic - e*r
  always_comb begin
    dea_s = fadd(dl12, -t2);
    deb_s = fadd(dea13, -er13);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dea13  <= dea_s.v;
      deac13 <= dea_s.clip | t2_c | dlc12;
      deb14  <= deb_s.v;
      debc14 <= deb_s.clip | deac13 | erc13;
    end
  end

  apc_mul #(.FRAC_BITS(FRAC_BITS)) u_dec (
    .clk, .en(adv), .a(val_t'(regs[REG_TIME_STEP])), .b(deb14),
    .clip_in(debc14), .p(dec), .clip_out(dec_c)
  );

  apc_delay #(.WIDTH(WORD_W), .DEPTH(T_DEC)) u_d_e (
    .clk, .en(adv), .d(in0.excite_center), .q(e18)
  );

  // New excitation
  always_comb begin
    en_s = fadd(val_t'(e18), dec);
    en_w = sat32(en_s.v);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      en19  <= en_w.v;
      enc19 <= en_s.clip | en_w.clip | dec_c;
    end
  end

  apc_delay #(.WIDTH(WORD_W + 1), .DEPTH(T_P2 - T_EN)) u_d_en (
    .clk, .en(adv), .d({en19, enc19}), .q({en85, enc85})
  );

  // Recovery drive g = r + k*e*(e-b-1)
  apc_delay #(.WIDTH(WORD_W), .DEPTH(T_G1)) u_d_r8 (
    .clk, .en(adv), .d(in0.recover_center), .q(r8)
  );

  always_comb begin
    g_s = fadd(val_t'(r8), g1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g9  <= g_s.v;
      gc9 <= g_s.clip | g1_c;
    end
  end

  apc_delay #(.WIDTH(VAL_W + 1), .DEPTH(T_RATE - T_G)) u_d_g (
    .clk, .en(adv), .d({g9, gc9}), .q({g77, gc77})
  );

  // mu1*r/(mu2+e)
  apc_div u_div (
    .clk, .en(adv), .mu1(regs[REG_MU1]), .r(r1), .den(den1[DEN_W-1:0]),
    .q(q), .clip_out(q_c)
  );

  always_comb begin
    rate_s = fadd(val_t'(regs[REG_EPSILON]), q);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rate77  <= rate_s.v;
      ratec77 <= rate_s.clip | q_c;
    end
  end

  apc_mul #(.FRAC_BITS(FRAC_BITS)) u_p (
    .clk, .en(adv), .a(rate77), .b(g77), .clip_in(ratec77 | gc77), .p(p), .clip_out(p_c)
  );
  apc_mul #(.FRAC_BITS(FRAC_BITS)) u_p2 (
    .clk, .en(adv), .a(val_t'(regs[REG_TIME_STEP])), .b(-p), .clip_in(p_c),
    .p(p2), .clip_out(p2_c)
  );

  apc_delay #(.WIDTH(WORD_W + 1), .DEPTH(T_P2 - 1)) u_d_rf (
    .clk, .en(adv), .d({r1, fault1}), .q({r85, f85})
  );

  // Output word: keep r on a bad divisor
  always_comb begin
    rn_s = fadd(val_t'(r85), p2);
    rn_w = sat32(rn_s.v);
    out_next.excite_next  = en85;
    out_next.recover_next = f85 ? r85 : rn_w.v;
    out_next.saturated    = enc85 | (!f85 & (rn_s.clip | rn_w.clip | p2_c));
    out_next.divide_fault = f85;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cell_out.data <= out_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_reset_empties: assert property (@(posedge clk) rst |=> !cell_out.valid)
    else $error("output valid right after reset");

  a_freeze_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("stage valids moved during a stall");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (cell_out.valid && !cell_out.ready) |-> !cell_in.ready)
    else $error("input taken while output word is blocked");

  a_fault_keeps_r: assert property (@(posedge clk) disable iff (rst)
    (adv && vld[T_P2] && f85) |=> (cell_out.data.recover_next == $past(r85)))
    else $error("recovery changed on a bad divisor");
`endif

endmodule

// ----- hdl/apc_delay.sv -----
// Enabled shift line that carries a field alongside the pipeline.
// Depends on nothing.
module apc_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] taps [DEPTH];

  // Advance all taps together
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[DEPTH-1];

endmodule

// ----- hdl/apc_mul.sv -----
// Four-stage fixed-point multiplier: sign/magnitude, four 31x31 partial
// products, sum, then shift by the fraction width and clamp. Uses apc_pkg.
module apc_mul #(
  parameter int FRAC_BITS = apc_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          en,
  input  apc_pkg::val_t a,
  input  apc_pkg::val_t b,
  input  logic          clip_in,
  output apc_pkg::val_t p,
  output logic          clip_out
);
  import apc_pkg::*;

  logic                neg1, neg2, neg3;
  logic                c1, c2, c3;
  mag_t                ma1, mb1;
  logic [MAG_W-1:0]    ll2, lh2, hl2, hh2;
  logic [PROD_W-1:0]   prod3;
  logic [PROD_W-1:0]   shifted;
  logic                ovf;
  mag_t                mag;

  // Stage 1: split into sign and magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= a[VAL_W-1] ^ b[VAL_W-1];
      c1   <= clip_in;
      ma1  <= magnitude(a);
      mb1  <= magnitude(b);
    end
  end

  // Stage 2: partial products of the halves
  always_ff @(posedge clk) begin
    if (en) begin
      neg2 <= neg1;
      c2   <= c1;
      ll2  <= MAG_W'(ma1[HALF_W-1:0])     * MAG_W'(mb1[HALF_W-1:0]);
      lh2  <= MAG_W'(ma1[HALF_W-1:0])     * MAG_W'(mb1[MAG_W-1:HALF_W]);
      hl2  <= MAG_W'(ma1[MAG_W-1:HALF_W]) * MAG_W'(mb1[HALF_W-1:0]);
      hh2  <= MAG_W'(ma1[MAG_W-1:HALF_W]) * MAG_W'(mb1[MAG_W-1:HALF_W]);
    end
  end

  // Stage 3: add the partial products
  always_ff @(posedge clk) begin
    if (en) begin
      neg3  <= neg2;
      c3    <= c2;
      prod3 <= {hh2, ll2} + ((PROD_W'(lh2) + PROD_W'(hl2)) << HALF_W);
    end
  end

  // Drop fraction bits, clamp the magnitude
  always_comb begin
    shifted = prod3 >> FRAC_BITS;
    ovf     = |shifted[PROD_W-1:MAG_W];
    mag     = ovf ? LIM : shifted[MAG_W-1:0];
  end

  // Stage 4: restore the sign
  always_ff @(posedge clk) begin
    if (en) begin
      p        <= neg3 ? -val_t'({1'b0, mag}) : val_t'({1'b0, mag});
      clip_out <= c3 | ovf;
    end
  end

endmodule

// ----- hdl/apc_div.sv -----
// Pipelined restoring divider for mu1*r/den: numerator product in two
// stages, one quotient bit per stage, then clamp and sign. Uses apc_pkg.
module apc_div (
  input  logic                      clk,
  input  logic                      en,
  input  apc_pkg::coef_t            mu1,
  input  apc_pkg::word_t            r,
  input  logic [apc_pkg::DEN_W-1:0] den,
  output apc_pkg::val_t             q,
  output logic                      clip_out
);
  import apc_pkg::*;

  logic [WORD_W-1:0] mr;
  logic              neg1;
  logic [PP_W-1:0]   p0_1, p1_1;
  logic [DEN_W-1:0]  den1;

  logic [DEN_W-1:0]  rem_s [NUM_W+1];
  logic [NUM_W-1:0]  nq_s  [NUM_W+1];
  logic [DEN_W-1:0]  den_s [NUM_W+1];
  logic              neg_s [NUM_W+1];

  logic              ovf;
  mag_t              mag;

  assign mr = r[WORD_W-1] ? WORD_W'(-r) : WORD_W'(r);

  // Stage 1: two partial products of mu1 and |r|
  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= r[WORD_W-1];
      den1 <= den;
      p0_1 <= PP_W'(mu1[LO_W-1:0])     * PP_W'(mr);
      p1_1 <= PP_W'(mu1[REG_W-1:LO_W]) * PP_W'(mr);
    end
  end

  // Stage 2: full numerator, remainder cleared
  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= '0;
      nq_s[0]  <= NUM_W'(p0_1) + (NUM_W'(p1_1) << LO_W);
      den_s[0] <= den1;
      neg_s[0] <= neg1;
    end
  end

  // One quotient bit per stage, numerator bits shift out as quotient shifts in
  for (genvar k = 1; k <= NUM_W; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic           take;

    always_comb begin
      trial = {rem_s[k-1], nq_s[k-1][NUM_W-1]};
      take  = trial >= {1'b0, den_s[k-1]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k] <= take ? DEN_W'(trial - {1'b0, den_s[k-1]}) : DEN_W'(trial);
        nq_s[k]  <= {nq_s[k-1][NUM_W-2:0], take};
        den_s[k] <= den_s[k-1];
        neg_s[k] <= neg_s[k-1];
      end
    end
  end

  // Clamp the quotient magnitude
  always_comb begin
    ovf = |nq_s[NUM_W][NUM_W-1:MAG_W];
    mag = ovf ? LIM : nq_s[NUM_W][MAG_W-1:0];
  end

  // Last stage: apply the sign of r
  always_ff @(posedge clk) begin
    if (en) begin
      q        <= neg_s[NUM_W] ? -val_t'({1'b0, mag}) : val_t'({1'b0, mag});
      clip_out <= ovf;
    end
  end

endmodule

// ----- dv/tb_aliev_panfilov_cell_update.sv -----
`timescale 1ns / 1ps
// Testbench for aliev_panfilov_cell_update: drives cell words with random gaps and
// output stalls, predicts each result in fixed point and checks the whole word, printing each field on a mismatch.
// Depends on apc_pkg, apc_stream_if and the block itself.
module tb_aliev_panfilov_cell_update;
  import apc_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FRAC;
  localparam logic [127:0] LIMQ = 128'h3FFF_FFFF_FFFF_FFFF;
  localparam longint LIML = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam coef_t COEF_MAX = '1;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  coef_t cfg_data;

  apc_stream_if #(.payload_t(in_word_t)) cell_in_if ();
  apc_stream_if #(.payload_t(out_word_t)) cell_out_if ();

  aliev_panfilov_cell_update dut (
    .clk(clk),
    .rst(rst),
    .cell_in(cell_in_if),
    .cell_out(cell_out_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Coefficients as the block should hold them
  coef_t coef [NUM_REGS];
  out_word_t cell_results_due [$];
  bit clip_seen;
  int mismatches;
  int cells_sent;
  int cells_checked;
  int burst_left;
  int hold_req;
  int hold_left;
  int stall_mode;
  int stall_count;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- prediction
  function automatic logic [63:0] abs64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint clamp_mag(bit neg, logic [127:0] m);
    logic [127:0] v;
    v = m;
    if (v > LIMQ) begin
      clip_seen = 1'b1;
      v = LIMQ;
    end
    return neg ? -longint'(v[63:0]) : longint'(v[63:0]);
  endfunction

  function automatic longint q_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > LIML) begin
      clip_seen = 1'b1;
      s = LIML;
    end else if (s < -LIML) begin
      clip_seen = 1'b1;
      s = -LIML;
    end
    return s;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    logic [127:0] p;
    p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    return clamp_mag((a < 0) != (b < 0), p >> FRAC);
  endfunction

  // mu1 * r / den, den known positive
  function automatic longint q_rate_div(coef_t mu1, longint r, longint den);
    logic [127:0] n;
    n = {88'd0, mu1} * {64'd0, abs64(r)};
    return clamp_mag(r < 0, n / {64'd0, den});
  endfunction

  function automatic longint clamp_word(longint v);
    if (v > 64'sd2147483647) begin
      clip_seen = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clip_seen = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic out_word_t euler_step(in_word_t c);
    longint dt, dd, k, a, b, eps, mu2, e, r, lap, de, en, rn, den, g, rate;
    out_word_t res;
    dt  = longint'(coef[REG_TIME_STEP]);
    dd  = longint'(coef[REG_DIFFUSION]);
    k   = longint'(coef[REG_GAIN_K]);
    a   = longint'(coef[REG_THRESHOLD_A]);
    b   = longint'(coef[REG_RECOVERY_B]);
    eps = longint'(coef[REG_EPSILON]);
    mu2 = longint'(coef[REG_MU2]);
    e   = longint'(c.excite_center);
    r   = longint'(c.recover_center);
    clip_seen = 1'b0;
    lap = longint'(c.excite_xm) + longint'(c.excite_xp) + longint'(c.excite_ym)
        + longint'(c.excite_yp) + longint'(c.excite_zm) + longint'(c.excite_zp) - 6 * e;
    // excitation: diffusion, cubic reaction, coupling to recovery
    de = q_mul(dd, lap);
    de = q_add(de, -q_mul(q_mul(q_mul(k, e), q_add(e, -a)), q_add(e, -ONE)));
    de = q_add(de, -q_mul(e, r));
    en = clamp_word(q_add(e, q_mul(dt, de)));
    // recovery: hold r when the rate divisor is not positive
    den = mu2 + e;
    res.divide_fault = den <= 0;
    if (den <= 0) begin
      rn = r;
    end else begin
      g = q_add(r, q_mul(q_mul(k, e), q_add(q_add(e, -b), -ONE)));
      rate = q_add(eps, q_rate_div(coef[REG_MU1], r, den));
      rn = clamp_word(q_add(r, q_mul(dt, -q_mul(rate, g))));
    end
    res.excite_next  = word_t'(en);
    res.recover_next = word_t'(rn);
    res.saturated    = clip_seen;
    return res;
  endfunction

  // ---------------------------------------------------------------- drivers
  // Send one word; called and returning at a rising edge
  task automatic send_cell(in_word_t c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        cell_in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cell_in_if.valid <= 1'b1;
    cell_in_if.data  <= c;
    do @(negedge clk); while (!cell_in_if.ready);
    @(posedge clk);
    cell_results_due.push_back(euler_step(c));
    cells_sent++;
  endtask

  // Wait until every result is back, then let the pipeline settle
  task automatic drain();
    cell_in_if.valid <= 1'b0;
    while (cell_results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Load all eight coefficients back to back; block must be idle
  task automatic load_coefs(coef_t vals [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data  <= vals[i];
      coef[i] = vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- stimulus
  function automatic word_t q_near(int lo_q, int hi_q);
    return word_t'($signed($urandom_range(0, hi_q - lo_q)) + lo_q);
  endfunction

  function automatic in_word_t rand_cell();
    in_word_t c;
    word_t base;
    if ($urandom_range(0, 4) == 0) begin
      c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      base = q_near(-(1 << 24), 3 << 24);
      c.excite_center  = base;
      c.recover_center = q_near(-(2 << 24), 4 << 24);
      c.excite_xm = base + q_near(-(1 << 23), 1 << 23);
      c.excite_xp = base + q_near(-(1 << 23), 1 << 23);
      c.excite_ym = base + q_near(-(1 << 23), 1 << 23);
      c.excite_yp = base + q_near(-(1 << 23), 1 << 23);
      c.excite_zm = base + q_near(-(1 << 23), 1 << 23);
      c.excite_zp = base + q_near(-(1 << 23), 1 << 23);
    end
    return c;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_cell(rand_cell());
  endtask

  function automatic in_word_t flat_cell(word_t e, word_t r, word_t nb);
    return '{e, r, nb, nb, nb, nb, nb, nb};
  endfunction

  task automatic test_directed();
    word_t wmax, wmin;
    wmax = 32'sh7FFF_FFFF;
    wmin = 32'sh8000_0000;
    send_cell(flat_cell(0, 0, 0));
    send_cell(flat_cell(wmax, wmax, wmax));
    send_cell(flat_cell(wmin, wmin, wmin));
    send_cell(flat_cell(wmax, wmin, wmin));
    send_cell(flat_cell(wmin, wmax, wmax));
    send_cell(flat_cell(32'sh0100_0000, 0, 0));
    send_cell(flat_cell(32'sh0100_0000, 32'sh0080_0000, 32'sh0100_0000));
    send_cell(flat_cell(32'sh0019_999A, 0, 32'sh0020_0000));
    // divisor exactly zero, just negative and just positive
    send_cell(flat_cell(-word_t'(REG_RESET[REG_MU2]), 32'sh0100_0000, 0));
    send_cell(flat_cell(-word_t'(REG_RESET[REG_MU2]) - 1, 32'sh0100_0000, 0));
    send_cell(flat_cell(-word_t'(REG_RESET[REG_MU2]) + 1, 32'sh0100_0000, 0));
    send_cell(flat_cell(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555));
    send_cell(flat_cell(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA));
    send_cell('{0, 0, wmax, wmin, wmax, wmin, wmax, wmin});
    send_cell('{32'sh0200_0000, wmin, 0, 0, 0, 0, 0, 0});
    send_cell('{32'sh0200_0000, wmax, 0, 0, 0, 0, 0, 0});
    drain();
  endtask

  task automatic test_swept_coefs();
    coef_t v [NUM_REGS];
    repeat (3) begin
      for (int i = 0; i < NUM_REGS; i++)
        v[i] = (REG_RESET[i] * $urandom_range(1, 16)) >> $urandom_range(0, 3);
      load_coefs(v);
      run_random(100);
      drain();
    end
  endtask

  task automatic test_extreme_coefs();
    coef_t v [NUM_REGS];
    foreach (v[i]) v[i] = '0;
    load_coefs(v);
    run_random(50);
    drain();
    foreach (v[i]) v[i] = COEF_MAX;
    load_coefs(v);
    run_random(50);
    drain();
  endtask

  task automatic test_divide_fault();
    coef_t v [NUM_REGS];
    in_word_t c;
    v = REG_RESET;
    v[REG_MU2] = '0;
    load_coefs(v);
    repeat (60) begin
      c = rand_cell();
      if ($urandom_range(0, 1) == 0) c.excite_center = -q_near(0, 2 << 24);
      send_cell(c);
    end
    drain();
  endtask

  // Hold the output long enough for the pipeline to fill and stall the input
  task automatic test_backpressure();
    load_coefs(REG_RESET);
    hold_req = 400;
    run_random(150);
    drain();
  endtask

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (stall_count == 0) begin
      stall_mode  = $urandom_range(0, 3);
      stall_count = $urandom_range(32, 160);
    end
    stall_count--;
    if (hold_left > 0) begin
      hold_left--;
      cell_out_if.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: cell_out_if.ready <= 1'b1;
        1: cell_out_if.ready <= $urandom_range(0, 3) != 0;
        2: cell_out_if.ready <= $urandom_range(0, 1);
        default: cell_out_if.ready <= (stall_count % 4) == 0;
      endcase
    end
  end

  // Check each word the sink takes against the oldest prediction
  always @(negedge clk) begin
    out_word_t want, got;
    if (!rst && cell_out_if.valid && cell_out_if.ready) begin
      got = cell_out_if.data;
      if (cell_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word %h", got);
      end else begin
        want = cell_results_due.pop_front();
        cells_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: e' exp %h got %h, r' exp %h got %h, sat exp %b got %b, fault exp %b got %b",
                     want.excite_next, got.excite_next, want.recover_next, got.recover_next,
                     want.saturated, got.saturated, want.divide_fault, got.divide_fault);
        end
      end
    end
  end

  // ---------------------------------------------------------------- main
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cell_in_if.valid = 1'b0;
    cell_in_if.data = '0;
    cell_out_if.ready = 1'b0;
    coef = REG_RESET;
    mismatches = 0;
    cells_sent = 0;
    cells_checked = 0;
    burst_left = 0;
    hold_req = 0;
    hold_left = 0;
    stall_count = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    run_random(324);
    drain();
    test_swept_coefs();
    test_extreme_coefs();
    test_divide_fault();
    test_backpressure();
    drain();
    repeat (100) @(posedge clk);

    $display("Sent %0d cell words, checked %0d, over reset, swept, zero, full-scale",
             cells_sent, cells_checked);
    $display("and zero-mu2 coefficient sets, with a long output hold; %0d mismatches",
             mismatches);
    if (mismatches == 0 && cell_results_due.size() == 0) begin
      $display("PASS aliev_panfilov_cell_update");
    end else begin
      $display("FAIL aliev_panfilov_cell_update");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("FAIL aliev_panfilov_cell_update");
    $finish;
  end

endmodule
